/* sv/arrive_pkg.sv */
// Shared constants, register codes and helper functions of the arrive steering unit.
package arrive_pkg;

   // Iteration counts of the pipelined square roots and dividers.
   localparam int SQA_N = 33;   // root bits of the offset distance
   localparam int SQB_N = 34;   // root bits of the steering length
   localparam int DIV_N = 32;   // quotient bits of every divider

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_MAX_SPEED   = 2'd0,
      CSR_MAX_ACCEL   = 2'd1,
      CSR_SLOW_RADIUS = 2'd2
   } csr_idx_type;

   // Magnitude of a 33-bit two's complement value; -2^32 still fits.
   function automatic logic [32:0] mag33(input logic [32:0] v);
      logic [32:0] n;
      n = v[32] ? (~v + 33'd1) : v;
      return n;
   endfunction

   // Magnitude of a 34-bit two's complement value known to stay below 2^33.
   function automatic logic [32:0] mag34(input logic [33:0] v);
      logic [33:0] n;
      n = v[33] ? (~v + 34'd1) : v;
      return n[32:0];
   endfunction

   // Apply a sign to an unsigned quotient and clamp to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic [31:0] q, input logic neg);
      logic [31:0] r;
      if (!neg) begin
         r = q[31] ? 32'h7FFF_FFFF : q;
      end else if (q > 32'h8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = ~q + 32'd1;
      end
      return r;
   endfunction

endpackage

/* sv/arrive_steering_unit.sv */
// Arrive steering unit: fully pipelined fixed-point arrive behavior with config registers.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | target, pos, vel (x, y, z), Q16.16
//   rsp     | out       | rsp_valid / rsp_stall  | accel (x, y, z), Q16.16, saturated
//   csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// One beat enters per cycle while the pipeline is not held. The depth up to the response
// register is set by two bit-per-stage square roots (33 and 34 stages) and three
// bit-per-stage dividers (32 stages each), with one multiplier stage ahead of each.
// Reset clears the valid bits and sets every configuration register to 1.0; no clearing pass is needed.
// The whole pipeline holds only when the response register is full and stalled and the
// last stage holds a beat; otherwise every stage advances and requests keep flowing.
module arrive_steering_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_accel_x,
   output logic signed [31:0] rsp_accel_y,
   output logic signed [31:0] rsp_accel_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int SA = arrive_pkg::SQA_N;
   localparam int SB = arrive_pkg::SQB_N;
   localparam int DV = arrive_pkg::DIV_N;

   // Configuration registers.
   logic [31:0] max_speed_ff, max_accel_ff, slow_radius_ff;

   // Flow control.
   logic out_take, adv;

   // Entry stage: offsets and velocity.
   logic              e_valid_ff;
   logic [2:0][32:0]  e_d_ff;
   logic [2:0][31:0]  e_vel_ff;

   // Square stage for the offset.
   logic              q_valid_ff;
   logic [2:0][65:0]  q_sq_ff;
   logic [2:0][32:0]  q_d_ff;
   logic [2:0][31:0]  q_vel_ff;

   // Distance square root.
   logic              sa_valid_ff [0:SA];
   logic [65:0]       sa_rad_ff   [0:SA];
   logic [32:0]       sa_root_ff  [0:SA];
   logic [34:0]       sa_rem_ff   [0:SA];
   logic [2:0][32:0]  sa_d_ff     [0:SA];
   logic [2:0][31:0]  sa_vel_ff   [0:SA];

   // Speed divider: max_speed * dist / slow_radius.
   logic [63:0]       m1_prod;
   logic              da_valid_ff [0:DV];
   logic [31:0]       da_rem_ff   [0:DV];
   logic [31:0]       da_low_ff   [0:DV];
   logic [32:0]       da_dist_ff  [0:DV];
   logic              da_far_ff   [0:DV];
   logic [2:0][32:0]  da_d_ff     [0:DV];
   logic [2:0][31:0]  da_vel_ff   [0:DV];

   // Desired velocity dividers: |d| * speed / dist, three lanes.
   logic [31:0]       m2_spd;
   logic [2:0][64:0]  m2_prod;
   logic              db_valid_ff [0:DV];
   logic [2:0][32:0]  db_rem_ff   [0:DV];
   logic [2:0][31:0]  db_low_ff   [0:DV];
   logic [2:0]        db_sgn_ff   [0:DV];
   logic [32:0]       db_dist_ff  [0:DV];
   logic              db_zero_ff  [0:DV];
   logic [2:0][31:0]  db_vel_ff   [0:DV];

   // Steering vector and its squares.
   logic [2:0][33:0]  a_in;
   logic              a_valid_ff;
   logic [2:0][33:0]  a_ff;
   logic              b_valid_ff;
   logic [2:0][65:0]  b_sq_ff;
   logic [2:0][33:0]  b_a_ff;

   // Length square root.
   logic              sb_valid_ff [0:SB];
   logic [67:0]       sb_rad_ff   [0:SB];
   logic [33:0]       sb_root_ff  [0:SB];
   logic [35:0]       sb_rem_ff   [0:SB];
   logic [2:0][33:0]  sb_a_ff     [0:SB];

   // Output dividers: |a| * max_accel / len, three lanes.
   logic [2:0][64:0]  m3_prod;
   logic              dc_valid_ff [0:DV];
   logic [2:0][33:0]  dc_rem_ff   [0:DV];
   logic [2:0][31:0]  dc_low_ff   [0:DV];
   logic [2:0]        dc_sgn_ff   [0:DV];
   logic [33:0]       dc_len_ff   [0:DV];
   logic              dc_zero_ff  [0:DV];

   // Response register.
   logic              rsp_valid_ff;
   logic [2:0][31:0]  rsp_accel_ff;
   logic [2:0][31:0]  fin_accel;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff   <= 32'h0001_0000;
         max_accel_ff   <= 32'h0001_0000;
         slow_radius_ff <= 32'h0001_0000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            arrive_pkg::CSR_MAX_SPEED:   max_speed_ff   <= csr_data;
            arrive_pkg::CSR_MAX_ACCEL:   max_accel_ff   <= csr_data;
            arrive_pkg::CSR_SLOW_RADIUS: slow_radius_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline moves unless a full, stalled response would be overwritten.
   assign out_take  = !rsp_valid_ff || !rsp_stall;
   assign adv       = out_take || !dc_valid_ff[DV];
   assign req_stall = !adv;

   // Entry stage: exact 33-bit offsets.
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_d_ff[0]   <= {req_target_x[31], req_target_x} - {req_pos_x[31], req_pos_x};
         e_d_ff[1]   <= {req_target_y[31], req_target_y} - {req_pos_y[31], req_pos_y};
         e_d_ff[2]   <= {req_target_z[31], req_target_z} - {req_pos_z[31], req_pos_z};
         e_vel_ff[0] <= req_vel_x;
         e_vel_ff[1] <= req_vel_y;
         e_vel_ff[2] <= req_vel_z;
      end
   end

   // Square each offset component.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (adv) begin
         q_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            q_sq_ff[i] <= arrive_pkg::mag33(e_d_ff[i]) * arrive_pkg::mag33(e_d_ff[i]);
         end
         q_d_ff   <= e_d_ff;
         q_vel_ff <= e_vel_ff;
      end
   end

   // Sum of squares seeds the distance square root.
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         sa_valid_ff[0] <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_rad_ff[0]  <= q_sq_ff[0] + q_sq_ff[1] + q_sq_ff[2];
         sa_root_ff[0] <= '0;
         sa_rem_ff[0]  <= '0;
         sa_d_ff[0]    <= q_d_ff;
         sa_vel_ff[0]  <= q_vel_ff;
      end
   end

   // Distance square root, one root bit per stage.
   for (genvar k = 0; k < SA; k++) begin : g_sqrt_a
      logic [36:0] cur, trial, diff;
      logic        ge;

      assign cur   = {sa_rem_ff[k], sa_rad_ff[k][65:64]};
      assign trial = {2'b00, sa_root_ff[k], 2'b01};
      assign diff  = cur - trial;
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sa_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sa_valid_ff[k+1] <= sa_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sa_rad_ff[k+1]  <= {sa_rad_ff[k][63:0], 2'b00};
            sa_root_ff[k+1] <= {sa_root_ff[k][31:0], ge};
            sa_rem_ff[k+1]  <= ge ? diff[34:0] : cur[34:0];
            sa_d_ff[k+1]    <= sa_d_ff[k];
            sa_vel_ff[k+1]  <= sa_vel_ff[k];
         end
      end
   end

   // Speed product; below the radius the distance fits 32 bits.
   assign m1_prod = max_speed_ff * sa_root_ff[SA][31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         da_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         da_valid_ff[0] <= sa_valid_ff[SA];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         da_rem_ff[0]  <= m1_prod[63:32];
         da_low_ff[0]  <= m1_prod[31:0];
         da_dist_ff[0] <= sa_root_ff[SA];
         da_far_ff[0]  <= sa_root_ff[SA] > {1'b0, slow_radius_ff};
         da_d_ff[0]    <= sa_d_ff[SA];
         da_vel_ff[0]  <= sa_vel_ff[SA];
      end
   end

   // Speed divider; quotient bits shift into the low word.
   for (genvar k = 0; k < DV; k++) begin : g_div_a
      logic [32:0] cur, diff;
      logic        ge;

      assign cur  = {da_rem_ff[k], da_low_ff[k][31]};
      assign diff = cur - {1'b0, slow_radius_ff};
      assign ge   = cur >= {1'b0, slow_radius_ff};

      always_ff @(posedge clock) begin
         if (reset) begin
            da_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            da_valid_ff[k+1] <= da_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            da_rem_ff[k+1]  <= ge ? diff[31:0] : cur[31:0];
            da_low_ff[k+1]  <= {da_low_ff[k][30:0], ge};
            da_dist_ff[k+1] <= da_dist_ff[k];
            da_far_ff[k+1]  <= da_far_ff[k];
            da_d_ff[k+1]    <= da_d_ff[k];
            da_vel_ff[k+1]  <= da_vel_ff[k];
         end
      end
   end

   // Desired speed and the per-lane products for the direction scaling.
   assign m2_spd = da_far_ff[DV] ? max_speed_ff : da_low_ff[DV];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m2_prod[i] = arrive_pkg::mag33(da_d_ff[DV][i]) * m2_spd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         db_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         db_valid_ff[0] <= da_valid_ff[DV];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            db_rem_ff[0][i] <= m2_prod[i][64:32];
            db_low_ff[0][i] <= m2_prod[i][31:0];
            db_sgn_ff[0][i] <= da_d_ff[DV][i][32];
         end
         db_dist_ff[0] <= da_dist_ff[DV];
         db_zero_ff[0] <= da_dist_ff[DV] == '0;
         db_vel_ff[0]  <= da_vel_ff[DV];
      end
   end

   // Desired velocity dividers, three lanes sharing the distance divisor.
   for (genvar k = 0; k < DV; k++) begin : g_div_b
      logic [2:0][32:0] rem_in;
      logic [2:0][31:0] low_in;

      always_comb begin
         logic [33:0] cur;
         logic [33:0] diff;
         logic        ge;
         for (int i = 0; i < 3; i++) begin
            cur       = {db_rem_ff[k][i], db_low_ff[k][i][31]};
            diff      = cur - {1'b0, db_dist_ff[k]};
            ge        = cur >= {1'b0, db_dist_ff[k]};
            rem_in[i] = ge ? diff[32:0] : cur[32:0];
            low_in[i] = {db_low_ff[k][i][30:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            db_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            db_valid_ff[k+1] <= db_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            db_rem_ff[k+1]  <= rem_in;
            db_low_ff[k+1]  <= low_in;
            db_sgn_ff[k+1]  <= db_sgn_ff[k];
            db_dist_ff[k+1] <= db_dist_ff[k];
            db_zero_ff[k+1] <= db_zero_ff[k];
            db_vel_ff[k+1]  <= db_vel_ff[k];
         end
      end
   end

   // Steering vector: signed desired velocity minus current velocity.
   always_comb begin
      logic [33:0] want;
      for (int i = 0; i < 3; i++) begin
         want = {2'b00, db_low_ff[DV][i]};
         if (db_zero_ff[DV]) begin
            want = '0;
         end else if (db_sgn_ff[DV][i]) begin
            want = ~want + 34'd1;
         end
         a_in[i] = want - {{2{db_vel_ff[DV][i][31]}}, db_vel_ff[DV][i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= db_valid_ff[DV];
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= a_in;
         for (int i = 0; i < 3; i++) begin
            b_sq_ff[i] <= arrive_pkg::mag34(a_ff[i]) * arrive_pkg::mag34(a_ff[i]);
         end
         b_a_ff <= a_ff;
      end
   end

   // Sum of squares seeds the length square root.
   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         sb_valid_ff[0] <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_rad_ff[0]  <= {2'b00, b_sq_ff[0]} + {2'b00, b_sq_ff[1]} + {2'b00, b_sq_ff[2]};
         sb_root_ff[0] <= '0;
         sb_rem_ff[0]  <= '0;
         sb_a_ff[0]    <= b_a_ff;
      end
   end

   // Length square root, one root bit per stage.
   for (genvar k = 0; k < SB; k++) begin : g_sqrt_b
      logic [37:0] cur, trial, diff;
      logic        ge;

      assign cur   = {sb_rem_ff[k], sb_rad_ff[k][67:66]};
      assign trial = {2'b00, sb_root_ff[k], 2'b01};
      assign diff  = cur - trial;
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sb_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sb_valid_ff[k+1] <= sb_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sb_rad_ff[k+1]  <= {sb_rad_ff[k][65:0], 2'b00};
            sb_root_ff[k+1] <= {sb_root_ff[k][32:0], ge};
            sb_rem_ff[k+1]  <= ge ? diff[35:0] : cur[35:0];
            sb_a_ff[k+1]    <= sb_a_ff[k];
         end
      end
   end

   // Products for the acceleration scaling.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m3_prod[i] = arrive_pkg::mag34(sb_a_ff[SB][i]) * max_accel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dc_valid_ff[0] <= sb_valid_ff[SB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dc_rem_ff[0][i] <= {1'b0, m3_prod[i][64:32]};
            dc_low_ff[0][i] <= m3_prod[i][31:0];
            dc_sgn_ff[0][i] <= sb_a_ff[SB][i][33];
         end
         dc_len_ff[0]  <= sb_root_ff[SB];
         dc_zero_ff[0] <= sb_root_ff[SB] == '0;
      end
   end

   // Acceleration dividers, three lanes sharing the length divisor.
   for (genvar k = 0; k < DV; k++) begin : g_div_c
      logic [2:0][33:0] rem_in;
      logic [2:0][31:0] low_in;

      always_comb begin
         logic [34:0] cur;
         logic [34:0] diff;
         logic        ge;
         for (int i = 0; i < 3; i++) begin
            cur       = {dc_rem_ff[k][i], dc_low_ff[k][i][31]};
            diff      = cur - {1'b0, dc_len_ff[k]};
            ge        = cur >= {1'b0, dc_len_ff[k]};
            rem_in[i] = ge ? diff[33:0] : cur[33:0];
            low_in[i] = {dc_low_ff[k][i][30:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dc_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dc_valid_ff[k+1] <= dc_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dc_rem_ff[k+1]  <= rem_in;
            dc_low_ff[k+1]  <= low_in;
            dc_sgn_ff[k+1]  <= dc_sgn_ff[k];
            dc_len_ff[k+1]  <= dc_len_ff[k];
            dc_zero_ff[k+1] <= dc_zero_ff[k];
         end
      end
   end

   // Sign, clamp and zero-vector handling.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin_accel[i] = dc_zero_ff[DV] ? '0
                                       : arrive_pkg::sat32(dc_low_ff[DV][i], dc_sgn_ff[DV][i]);
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= dc_valid_ff[DV];
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_accel_ff <= fin_accel;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_accel_x = rsp_accel_ff[0];
   assign rsp_accel_y = rsp_accel_ff[1];
   assign rsp_accel_z = rsp_accel_ff[2];

   // The request side only holds when a finished beat is blocked at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && dc_valid_ff[DV]))
      else $error("request stalled without a blocked response");

   // A finished distance root leaves a remainder no larger than twice the root.
   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      sa_valid_ff[SA] |-> (sa_rem_ff[SA] <= {1'b0, sa_root_ff[SA], 1'b0}))
      else $error("distance square root remainder out of range");

   // The lane-0 acceleration divider remainder stays below a nonzero length.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (dc_valid_ff[DV] && !dc_zero_ff[DV]) |-> (dc_rem_ff[DV][0] < dc_len_ff[DV]))
      else $error("acceleration divider remainder out of range");

endmodule
